[src/g2e_pkg.sv]
// ----------------------------------------------------------------------------
// g2e_pkg - shared types and constants of the geodetic to ECEF converter
// Field widths, the CORDIC arctangent table and the beat structures that
// travel through the cell chains.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ATAN_LEN          = 31;

  localparam int LON_W    = 32;
  localparam int LAT_W    = 32;
  localparam int H_W      = 28;
  localparam int OUT_W    = 34;
  localparam int RADIUS_W = 33;
  localparam int ECC_W    = 32;
  localparam int CFG_W    = 33;
  localparam int IDX_W    = 1;
  localparam int IN_W     = 96;
  localparam int OUTD_W   = 104;

  // CORDIC vector components and residual angle.
  localparam int VEC_W = 33;
  localparam int ANG_W = 34;
  // Square root working width, root width and quotient width.
  localparam int ROOT_W  = 64;
  localparam int ROOT_STEPS = 32;
  localparam int R_W     = 31;
  localparam int Q_W     = 49;

  localparam logic [IDX_W-1:0] REG_RADIUS = 1'd0;
  localparam logic [IDX_W-1:0] REG_ECC    = 1'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd6378137000;
  localparam logic [ECC_W-1:0]    ECC_RESET    = 32'd28752143;

  localparam logic signed [VEC_W-1:0] INV_GAIN     = 33'sh026DD3B6A;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER  = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] ANG_HALF     = 34'sd2147483648;

  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001
  };

  // Arctangent of 2^-i in binary angle units; zero past the end of the table.
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic [4:0] idx;
    idx = i[4:0];
    if (i < ATAN_LEN) begin
      return ANG_W'(ATAN_TAB[idx]);
    end
    return '0;
  endfunction

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cvec_t;

  typedef struct packed {
    cvec_t                 lon;
    cvec_t                 lat;
    logic                  flip;
    logic signed [H_W-1:0] h;
  } cord_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] cl;
    logic signed [VEC_W-1:0] sl;
    logic signed [VEC_W-1:0] cp;
    logic signed [VEC_W-1:0] sp;
    logic signed [H_W-1:0]   h;
  } side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] v;
    logic [ROOT_W-1:0] res;
    side_t             side;
  } root_t;

  typedef struct packed {
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] low;
    logic [Q_W-1:0] q;
    logic [R_W-1:0] r;
    side_t          side;
  } div_t;

endpackage

[src/g2e_cordic_cell.sv]
// ----------------------------------------------------------------------------
// g2e_cordic_cell - one rotation stage for longitude and latitude
// Turns both vectors by the stage's arctangent towards a zero residual.
// ----------------------------------------------------------------------------
module g2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  g2e_pkg::cord_t  in_data,
  output logic            out_valid,
  output g2e_pkg::cord_t  out_data
);

  localparam logic signed [g2e_pkg::ANG_W-1:0] ATAN = g2e_pkg::atan_step(STAGE);

  logic           valid_r;
  g2e_pkg::cord_t data_r;
  g2e_pkg::cord_t data_nxt;

  function automatic g2e_pkg::cvec_t rotate(input g2e_pkg::cvec_t v);
    logic signed [g2e_pkg::VEC_W-1:0] x;
    logic signed [g2e_pkg::VEC_W-1:0] y;
    logic signed [g2e_pkg::VEC_W-1:0] dx;
    logic signed [g2e_pkg::VEC_W-1:0] dy;
    logic signed [g2e_pkg::ANG_W-1:0] z;
    g2e_pkg::cvec_t                   o;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    if (z >= 0) begin
      o.x = x - dx;
      o.y = y + dy;
      o.z = z - ATAN;
    end else begin
      o.x = x + dx;
      o.y = y - dy;
      o.z = z + ATAN;
    end
    return o;
  endfunction

  always_comb begin
    data_nxt     = in_data;
    data_nxt.lon = rotate(in_data.lon);
    data_nxt.lat = rotate(in_data.lat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[src/g2e_root_cell.sv]
// ----------------------------------------------------------------------------
// g2e_root_cell - one step of the restoring square root
// Settles one bit of the root of 1 - e2 sin^2 lat.
// ----------------------------------------------------------------------------
module g2e_root_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  g2e_pkg::root_t  in_data,
  output logic            out_valid,
  output g2e_pkg::root_t  out_data
);

  localparam logic [g2e_pkg::ROOT_W-1:0] BIT =
    g2e_pkg::ROOT_W'(1) << (g2e_pkg::ROOT_W - 2 - 2 * K);

  logic                        valid_r;
  g2e_pkg::root_t              data_r;
  g2e_pkg::root_t              data_nxt;
  logic [g2e_pkg::ROOT_W-1:0]  trial;

  always_comb begin
    data_nxt = in_data;
    trial    = in_data.res + BIT;
    if (in_data.v >= trial) begin
      data_nxt.v   = in_data.v - trial;
      data_nxt.res = (in_data.res >> 1) + BIT;
    end else begin
      data_nxt.res = in_data.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[src/g2e_div_cell.sv]
// ----------------------------------------------------------------------------
// g2e_div_cell - one step of the restoring divider
// Brings down one dividend bit and settles one quotient bit of N.
// ----------------------------------------------------------------------------
module g2e_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  g2e_pkg::div_t  in_data,
  output logic           out_valid,
  output g2e_pkg::div_t  out_data
);

  logic                     valid_r;
  g2e_pkg::div_t            data_r;
  g2e_pkg::div_t            data_nxt;
  logic [g2e_pkg::R_W:0]    rem2;
  logic [g2e_pkg::R_W:0]    dsr;

  always_comb begin
    data_nxt     = in_data;
    rem2         = {in_data.rem, in_data.low[g2e_pkg::Q_W-1]};
    dsr          = {1'b0, in_data.r};
    data_nxt.low = in_data.low << 1;
    if (rem2 >= dsr) begin
      data_nxt.rem = g2e_pkg::R_W'(rem2 - dsr);
      data_nxt.q   = {in_data.q[g2e_pkg::Q_W-2:0], 1'b1};
    end else begin
      data_nxt.rem = rem2[g2e_pkg::R_W-1:0];
      data_nxt.q   = {in_data.q[g2e_pkg::Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[src/geodetic_to_ecef.sv]
// ----------------------------------------------------------------------------
// geodetic_to_ecef - geodetic position to earth-centred earth-fixed X, Y, Z
// Fully pipelined fixed-point conversion on a configurable ellipsoid.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries longitude and latitude as binary angles and
// a height in millimetres; each output beat carries the saturated X, Y and Z
// in millimetres. The ellipsoid's semi-major axis and first eccentricity
// squared sit in two registers behind the write port and must only be
// changed while no beat is in flight.
// Throughput is one beat per cycle while the skid register is free. The
// datapath is a chain of cells: one CORDIC cell per stage for both angles,
// 32 square root cells, 49 divider cells and the registered stages M1, M2,
// D0 and E1 to E6, the last of which feeds the output register.
// The output has a register and a skid register behind it. A stalled
// receiver first fills the skid register while input is still taken; once
// both are full the whole chain freezes and in_tready drops, and nothing is
// lost. Reset empties the chain and restores the WGS84 ellipsoid; there is
// no clearing pass, so the block accepts beats from the first cycle.
// ----------------------------------------------------------------------------
module geodetic_to_ecef #(
  parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [g2e_pkg::IDX_W-1:0]    cfg_index,
  input  logic [g2e_pkg::CFG_W-1:0]    cfg_data,
  // input beats
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // in_tdata: longitude_angle[31:0], latitude_angle[63:32], height_mm[91:64]
  input  logic [g2e_pkg::IN_W-1:0]     in_tdata,
  // result beats
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_tdata: x_mm[33:0], y_mm[67:34], z_mm[101:68]
  output logic [g2e_pkg::OUTD_W-1:0]   out_tdata
);

  localparam int VW    = g2e_pkg::VEC_W;
  localparam int P_W   = 51;
  localparam int UP_W  = 50;
  localparam int CR_W  = 50;
  localparam int QS_W  = 52;
  localparam int UQ_W  = 51;
  localparam int PC_W  = 54;
  localparam int MAG_W = 58;

  localparam logic signed [MAG_W:0] SAT_HI =
    {{(MAG_W + 2 - g2e_pkg::OUT_W){1'b0}}, {(g2e_pkg::OUT_W - 1){1'b1}}};
  localparam logic signed [MAG_W:0] SAT_LO =
    {{(MAG_W + 2 - g2e_pkg::OUT_W){1'b1}}, {(g2e_pkg::OUT_W - 1){1'b0}}};

  // Configuration registers.
  logic [g2e_pkg::RADIUS_W-1:0] radius_r;
  logic [g2e_pkg::ECC_W-1:0]    ecc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= g2e_pkg::RADIUS_RESET;
      ecc_r    <= g2e_pkg::ECC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        g2e_pkg::REG_RADIUS: radius_r <= cfg_data;
        g2e_pkg::REG_ECC:    ecc_r    <= cfg_data[g2e_pkg::ECC_W-1:0];
        default:             radius_r <= radius_r;
      endcase
    end
  end

  // The chain advances whenever the skid register is free.
  logic en;
  logic skid_v_r;
  logic out_v_r;
  assign en        = !skid_v_r;
  assign in_tready = en;

  function automatic logic [VW-1:0] mag_vec(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // Input preparation: longitude beyond a quarter turn is turned by half a
  // turn and the results negated later; latitude is clamped to the poles.
  logic signed [g2e_pkg::LON_W-1:0] lon_in;
  logic signed [g2e_pkg::LAT_W-1:0] lat_in;
  logic signed [g2e_pkg::ANG_W-1:0] lon_ext;
  logic signed [g2e_pkg::ANG_W-1:0] lat_ext;
  g2e_pkg::cord_t                   cd_in;

  always_comb begin
    lon_in  = in_tdata[31:0];
    lat_in  = in_tdata[63:32];
    lon_ext = g2e_pkg::ANG_W'(lon_in);
    lat_ext = g2e_pkg::ANG_W'(lat_in);
    cd_in.h     = in_tdata[91:64];
    cd_in.lon.x = g2e_pkg::INV_GAIN;
    cd_in.lon.y = '0;
    cd_in.lat.x = g2e_pkg::INV_GAIN;
    cd_in.lat.y = '0;
    priority if (lon_ext > g2e_pkg::ANG_QUARTER) begin
      cd_in.lon.z = lon_ext - g2e_pkg::ANG_HALF;
      cd_in.flip  = 1'b1;
    end else if (lon_ext < -g2e_pkg::ANG_QUARTER) begin
      cd_in.lon.z = lon_ext + g2e_pkg::ANG_HALF;
      cd_in.flip  = 1'b1;
    end else begin
      cd_in.lon.z = lon_ext;
      cd_in.flip  = 1'b0;
    end
    priority if (lat_ext > g2e_pkg::ANG_QUARTER) begin
      cd_in.lat.z = g2e_pkg::ANG_QUARTER;
    end else if (lat_ext < -g2e_pkg::ANG_QUARTER) begin
      cd_in.lat.z = -g2e_pkg::ANG_QUARTER;
    end else begin
      cd_in.lat.z = lat_ext;
    end
  end

  // CORDIC chain.
  g2e_pkg::cord_t cd   [CORDIC_STAGES+1];
  logic           cd_v [CORDIC_STAGES+1];
  assign cd[0]   = cd_in;
  assign cd_v[0] = in_tvalid;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    g2e_cordic_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (cd_v[i]),
      .in_data  (cd[i]),
      .out_valid(cd_v[i+1]),
      .out_data (cd[i+1])
    );
  end

  // M1: undo the longitude turn and square the latitude sine.
  logic                m1_v_r;
  g2e_pkg::side_t      m1_side_r;
  logic [2*VW-1:0]     m1_sq_r;
  g2e_pkg::side_t      m1_side_nxt;
  logic [VW-1:0]       usp_m1;

  always_comb begin
    m1_side_nxt.cl = cd[CORDIC_STAGES].flip ? -cd[CORDIC_STAGES].lon.x
                                            :  cd[CORDIC_STAGES].lon.x;
    m1_side_nxt.sl = cd[CORDIC_STAGES].flip ? -cd[CORDIC_STAGES].lon.y
                                            :  cd[CORDIC_STAGES].lon.y;
    m1_side_nxt.cp = cd[CORDIC_STAGES].lat.x;
    m1_side_nxt.sp = cd[CORDIC_STAGES].lat.y;
    m1_side_nxt.h  = cd[CORDIC_STAGES].h;
    usp_m1         = mag_vec(cd[CORDIC_STAGES].lat.y);
  end

  // M2: sin^2 clamped to one, then times e2.
  logic                m2_v_r;
  g2e_pkg::side_t      m2_side_r;
  logic [30:0]         m2_t_r;
  logic [2*VW-31:0]    s2_full;
  logic [30:0]         s2;
  logic [62:0]         t_prod;

  always_comb begin
    s2_full = m1_sq_r[2*VW-1:30];
    s2      = (s2_full > (2*VW-30)'(31'h40000000)) ? 31'h40000000 : s2_full[30:0];
    t_prod  = 63'(ecc_r) * 63'(s2);
  end

  // Square root chain on (1 - e2 sin^2) in Q60.
  g2e_pkg::root_t rt   [g2e_pkg::ROOT_STEPS+1];
  logic           rt_v [g2e_pkg::ROOT_STEPS+1];
  logic [30:0]    w_q30;

  always_comb begin
    w_q30       = 31'h40000000 - m2_t_r;
    rt[0].v     = {3'b000, w_q30, 30'b0};
    rt[0].res   = '0;
    rt[0].side  = m2_side_r;
  end
  assign rt_v[0] = m2_v_r;

  for (genvar k = 0; k < g2e_pkg::ROOT_STEPS; k++) begin : g_root
    g2e_root_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (rt_v[k]),
      .in_data  (rt[k]),
      .out_valid(rt_v[k+1]),
      .out_data (rt[k+1])
    );
  end

  // D0: rounded dividend (a << 30) + r / 2.
  logic                    d0_v_r;
  logic [63:0]             d0_dvd_r;
  logic [g2e_pkg::R_W-1:0] d0_rt_r;
  g2e_pkg::side_t          d0_side_r;
  logic [g2e_pkg::R_W-1:0] root_q30;

  assign root_q30 = rt[g2e_pkg::ROOT_STEPS].res[g2e_pkg::R_W-1:0];

  // Divider chain: the quotient never exceeds 49 bits, so the first
  // remainder is simply the top of the dividend.
  g2e_pkg::div_t dv   [g2e_pkg::Q_W+1];
  logic          dv_v [g2e_pkg::Q_W+1];

  always_comb begin
    dv[0].rem  = {16'b0, d0_dvd_r[63:g2e_pkg::Q_W]};
    dv[0].low  = d0_dvd_r[g2e_pkg::Q_W-1:0];
    dv[0].q    = '0;
    dv[0].r    = d0_rt_r;
    dv[0].side = d0_side_r;
  end
  assign dv_v[0] = d0_v_r;

  for (genvar j = 0; j < g2e_pkg::Q_W; j++) begin : g_div
    g2e_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dv_v[j]),
      .in_data  (dv[j]),
      .out_valid(dv_v[j+1]),
      .out_data (dv[j+1])
    );
  end

  logic [g2e_pkg::Q_W-1:0] n_mm;
  assign n_mm = dv[g2e_pkg::Q_W].q;

  // E1: N * e2 in two halves, and N + h.
  logic                    e1_v_r;
  logic [48:0]             e1_nhi_r;
  logic [63:0]             e1_nlo_r;
  logic signed [P_W-1:0]   e1_p_r;
  logic [g2e_pkg::Q_W-1:0] e1_n_r;
  g2e_pkg::side_t          e1_side_r;

  // E2: rounded N * e2 and |N + h|.
  logic                    e2_v_r;
  logic [CR_W-1:0]         e2_corr_r;
  logic [UP_W-1:0]         e2_up_r;
  logic                    e2_pneg_r;
  logic [g2e_pkg::Q_W-1:0] e2_n_r;
  g2e_pkg::side_t          e2_side_r;
  logic [64:0]             lo_rnd;

  assign lo_rnd = {1'b0, e1_nlo_r} + 65'h0_8000_0000;

  // E3: N(1 - e2) + h, and (N + h) times cos lat in two halves.
  logic                    e3_v_r;
  logic signed [QS_W-1:0]  e3_q_r;
  logic [52:0]             e3_ph_r;
  logic [62:0]             e3_pl_r;
  logic                    e3_pcneg_r;
  g2e_pkg::side_t          e3_side_r;
  logic [VW-1:0]           ucp;

  assign ucp = mag_vec(e2_side_r.cp);

  // E4: rounded (N + h) cos lat, and |N(1 - e2) + h|.
  logic                    e4_v_r;
  logic [PC_W-1:0]         e4_pc_r;
  logic                    e4_pcneg_r;
  logic [UQ_W-1:0]         e4_uq_r;
  logic                    e4_qneg_r;
  g2e_pkg::side_t          e4_side_r;
  logic [63:0]             pl_rnd;

  assign pl_rnd = {1'b0, e3_pl_r} + 64'h2000_0000;

  // E5: the three final products, each in two halves.
  logic                    e5_v_r;
  logic [56:0]             e5_xh_r;
  logic [62:0]             e5_xl_r;
  logic [56:0]             e5_yh_r;
  logic [62:0]             e5_yl_r;
  logic [53:0]             e5_zh_r;
  logic [62:0]             e5_zl_r;
  logic                    e5_xneg_r;
  logic                    e5_yneg_r;
  logic                    e5_zneg_r;
  logic [VW-1:0]           ucl;
  logic [VW-1:0]           usl;
  logic [VW-1:0]           usp;

  assign ucl = mag_vec(e4_side_r.cl);
  assign usl = mag_vec(e4_side_r.sl);
  assign usp = mag_vec(e4_side_r.sp);

  // E6: rounded magnitudes with their signs.
  logic                    e6_v_r;
  logic [MAG_W-1:0]        e6_xm_r;
  logic [MAG_W-1:0]        e6_ym_r;
  logic [MAG_W-1:0]        e6_zm_r;
  logic                    e6_xneg_r;
  logic                    e6_yneg_r;
  logic                    e6_zneg_r;
  logic [63:0]             xl_rnd;
  logic [63:0]             yl_rnd;
  logic [63:0]             zl_rnd;

  assign xl_rnd = {1'b0, e5_xl_r} + 64'h2000_0000;
  assign yl_rnd = {1'b0, e5_yl_r} + 64'h2000_0000;
  assign zl_rnd = {1'b0, e5_zl_r} + 64'h2000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      d0_v_r <= 1'b0;
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      e4_v_r <= 1'b0;
      e5_v_r <= 1'b0;
      e6_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= cd_v[CORDIC_STAGES];
      m2_v_r <= m1_v_r;
      d0_v_r <= rt_v[g2e_pkg::ROOT_STEPS];
      e1_v_r <= dv_v[g2e_pkg::Q_W];
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      e4_v_r <= e3_v_r;
      e5_v_r <= e4_v_r;
      e6_v_r <= e5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side_r  <= m1_side_nxt;
      m1_sq_r    <= (2*VW)'(usp_m1) * (2*VW)'(usp_m1);

      m2_side_r  <= m1_side_r;
      m2_t_r     <= t_prod[62:32];

      d0_dvd_r   <= {1'b0, radius_r, 30'b0} + 64'(root_q30[g2e_pkg::R_W-1:1]);
      d0_rt_r    <= root_q30;
      d0_side_r  <= rt[g2e_pkg::ROOT_STEPS].side;

      e1_nhi_r   <= 49'(n_mm[48:32]) * 49'(ecc_r);
      e1_nlo_r   <= 64'(n_mm[31:0]) * 64'(ecc_r);
      e1_p_r     <= $signed({2'b00, n_mm}) + P_W'(dv[g2e_pkg::Q_W].side.h);
      e1_n_r     <= n_mm;
      e1_side_r  <= dv[g2e_pkg::Q_W].side;

      e2_corr_r  <= CR_W'(e1_nhi_r) + CR_W'(lo_rnd[64:32]);
      e2_up_r    <= e1_p_r[P_W-1] ? UP_W'(-e1_p_r) : UP_W'(e1_p_r);
      e2_pneg_r  <= e1_p_r[P_W-1];
      e2_n_r     <= e1_n_r;
      e2_side_r  <= e1_side_r;

      e3_q_r     <= $signed({3'b000, e2_n_r}) - $signed({2'b00, e2_corr_r})
                    + QS_W'(e2_side_r.h);
      e3_ph_r    <= 53'(e2_up_r[UP_W-1:30]) * 53'(ucp);
      e3_pl_r    <= 63'(e2_up_r[29:0]) * 63'(ucp);
      e3_pcneg_r <= e2_pneg_r ^ e2_side_r.cp[VW-1];
      e3_side_r  <= e2_side_r;

      e4_pc_r    <= PC_W'(e3_ph_r) + PC_W'(pl_rnd[63:30]);
      e4_pcneg_r <= e3_pcneg_r;
      e4_uq_r    <= e3_q_r[QS_W-1] ? UQ_W'(-e3_q_r) : UQ_W'(e3_q_r);
      e4_qneg_r  <= e3_q_r[QS_W-1];
      e4_side_r  <= e3_side_r;

      e5_xh_r    <= 57'(e4_pc_r[PC_W-1:30]) * 57'(ucl);
      e5_xl_r    <= 63'(e4_pc_r[29:0]) * 63'(ucl);
      e5_yh_r    <= 57'(e4_pc_r[PC_W-1:30]) * 57'(usl);
      e5_yl_r    <= 63'(e4_pc_r[29:0]) * 63'(usl);
      e5_zh_r    <= 54'(e4_uq_r[UQ_W-1:30]) * 54'(usp);
      e5_zl_r    <= 63'(e4_uq_r[29:0]) * 63'(usp);
      e5_xneg_r  <= e4_pcneg_r ^ e4_side_r.cl[VW-1];
      e5_yneg_r  <= e4_pcneg_r ^ e4_side_r.sl[VW-1];
      e5_zneg_r  <= e4_qneg_r ^ e4_side_r.sp[VW-1];

      e6_xm_r    <= MAG_W'(e5_xh_r) + MAG_W'(xl_rnd[63:30]);
      e6_ym_r    <= MAG_W'(e5_yh_r) + MAG_W'(yl_rnd[63:30]);
      e6_zm_r    <= MAG_W'(e5_zh_r) + MAG_W'(zl_rnd[63:30]);
      e6_xneg_r  <= e5_xneg_r;
      e6_yneg_r  <= e5_yneg_r;
      e6_zneg_r  <= e5_zneg_r;
    end
  end

  // Sign and saturation into the output range.
  function automatic logic [g2e_pkg::OUT_W-1:0] sat_out(
    input logic neg, input logic [MAG_W-1:0] m
  );
    logic signed [MAG_W:0] v;
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (v > SAT_HI) begin
      return SAT_HI[g2e_pkg::OUT_W-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[g2e_pkg::OUT_W-1:0];
    end
    return v[g2e_pkg::OUT_W-1:0];
  endfunction

  logic [g2e_pkg::OUTD_W-1:0] push_data;
  logic                       push;
  logic                       pop;

  assign push_data = {2'b00, sat_out(e6_zneg_r, e6_zm_r), sat_out(e6_yneg_r, e6_ym_r),
                      sat_out(e6_xneg_r, e6_xm_r)};
  assign push      = e6_v_r && en;
  assign pop       = out_v_r && out_tready;

  // Output register with a skid register behind it.
  logic [g2e_pkg::OUTD_W-1:0] out_data_r;
  logic [g2e_pkg::OUTD_W-1:0] skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= skid_v_r && push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // The skid register only ever holds a beat queued behind the output one.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a beat while the output is empty");

  // The shortened divider needs its first remainder below the divisor.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    d0_v_r |-> ({16'b0, d0_dvd_r[63:g2e_pkg::Q_W]} < d0_rt_r))
    else $error("quotient of N does not fit the divider chain");

  // N e2 rounded never exceeds N, so N(1 - e2) stays non-negative.
  a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    e2_v_r |-> ({1'b0, e2_n_r} >= e2_corr_r))
    else $error("eccentricity correction larger than N");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench of the geodetic to ECEF converter
// Streams geodetic positions through the block under random sender bursts and
// receiver stalls, and checks every X, Y, Z beat against a bit-exact
// fixed-point predictor held in a small scoreboard, over several ellipsoids.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STAGES      = g2e_pkg::CORDIC_STAGES_DEF;
  localparam int  LATENCY     = STAGES + 90;
  localparam int  SETTLE      = LATENCY + 40;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic [g2e_pkg::OUT_W-1:0] x;
    logic [g2e_pkg::OUT_W-1:0] y;
    logic [g2e_pkg::OUT_W-1:0] z;
  } ecef_t;

  // The scoreboard keeps its own copy of the ellipsoid and a queue of the
  // coordinates expected from the positions that the block has accepted.
  class ecef_scoreboard;
    longint unsigned radius;
    longint unsigned ecc;
    ecef_t           coords_due[$];
    int              errors;

    function new();
      radius = 64'd6378137000;
      ecc    = 64'd28752143;
      errors = 0;
    endfunction

    function void set_reg(logic [g2e_pkg::IDX_W-1:0] idx, logic [g2e_pkg::CFG_W-1:0] val);
      if (idx == g2e_pkg::REG_RADIUS) begin
        radius = val;
      end else begin
        ecc = val[g2e_pkg::ECC_W-1:0];
      end
    endfunction

    function longint atan_units(int i);
      if (i < g2e_pkg::ATAN_LEN) begin
        return longint'(g2e_pkg::ATAN_TAB[i]);
      end
      return 0;
    endfunction

    // Rotation-mode CORDIC; angles past a quarter turn are turned by pi first.
    function void rotate(longint ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = ang;
      x = 64'sh26DD3B6A;
      y = 0;
      flip = 0;
      if (z > (64'sd1 <<< 30)) begin
        z = z - (64'sd1 <<< 31);
        flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
        z = z + (64'sd1 <<< 31);
        flip = 1;
      end
      for (int i = 0; i < STAGES && i < 40; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_units(i);
        end else begin
          x = x + dx; y = y - dy; z = z + atan_units(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      for (int k = 0; k < 32; k++) begin
        bitv = 64'd1 << (62 - 2 * k);
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
      end
      return res;
    endfunction

    // Product with a Q30 factor, rounded on the magnitude, halves away from 0.
    function longint scale_q30(longint a, longint c);
      bit neg;
      longint unsigned ua, uc, hi, lo, r;
      neg = (a < 0) != (c < 0);
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      hi = ua >> 30;
      lo = ua & ((64'd1 << 30) - 1);
      r  = hi * uc + ((lo * uc + (64'd1 << 29)) >> 30);
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function logic [g2e_pkg::OUT_W-1:0] clip(longint v);
      if (v > (64'sd1 <<< 33) - 1) v = (64'sd1 <<< 33) - 1;
      if (v < -(64'sd1 <<< 33)) v = -(64'sd1 <<< 33);
      return v[g2e_pkg::OUT_W-1:0];
    endfunction

    function void note_position(logic [g2e_pkg::IN_W-1:0] d);
      longint lon, lat, h, cl, sl, cp, sp, pc, p, q;
      longint unsigned s2, t, w, r, n, m;
      ecef_t e;
      lon = $signed(d[31:0]);
      lat = $signed(d[63:32]);
      h   = $signed(d[91:64]);
      if (lat > (64'sd1 <<< 30)) lat = 64'sd1 <<< 30;
      if (lat < -(64'sd1 <<< 30)) lat = -(64'sd1 <<< 30);
      rotate(lon, cl, sl);
      rotate(lat, cp, sp);
      s2 = longint'(sp * sp) >> 30;
      if (s2 > (64'd1 << 30)) s2 = 64'd1 << 30;
      t = (ecc * s2) >> 32;
      w = (64'd1 << 30) - t;
      r = isqrt(w << 30);
      n = ((radius << 30) + (r >> 1)) / r;
      m = n - ((n >> 32) * ecc + (((n & 64'hFFFF_FFFF) * ecc + (64'd1 << 31)) >> 32));
      p = longint'(n) + h;
      q = longint'(m) + h;
      pc = scale_q30(p, cp);
      e.x = clip(scale_q30(pc, cl));
      e.y = clip(scale_q30(pc, sl));
      e.z = clip(scale_q30(q, sp));
      coords_due.push_back(e);
    endfunction

    function void check_coords(logic [g2e_pkg::OUTD_W-1:0] d);
      ecef_t e;
      if (coords_due.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, d);
        errors++;
        return;
      end
      e = coords_due.pop_front();
      if (d[33:0] !== e.x) begin
        $display("%0t: x_mm expected %h actual %h", $time, e.x, d[33:0]);
        errors++;
      end
      if (d[67:34] !== e.y) begin
        $display("%0t: y_mm expected %h actual %h", $time, e.y, d[67:34]);
        errors++;
      end
      if (d[101:68] !== e.z) begin
        $display("%0t: z_mm expected %h actual %h", $time, e.z, d[101:68]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [g2e_pkg::IDX_W-1:0]    cfg_index = g2e_pkg::REG_RADIUS;
  logic [g2e_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [g2e_pkg::IN_W-1:0]     in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [g2e_pkg::OUTD_W-1:0]   out_tdata;

  ecef_scoreboard sb = new();
  longint cycles = 0;
  int     burst_left = 0;

  always #5 clk = ~clk;

  geodetic_to_ecef #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  // Both channels are observed at the rising edge, before the block's own
  // registers update, so the sampled values are the ones the handshake saw.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_position(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_coords(out_tdata);
  end

  // Watchdog: the limit sits well above the slowest correct run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver takes turns between three habits: always ready, random
  // stalls, or long stalls with short windows of readiness.
  always @(negedge clk) begin
    case ((cycles / 400) % 3)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_tready <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  // Called at a falling edge; returns at a falling edge once the beat was taken,
  // leaving in_tvalid high within a burst so that a following beat can go straight on.
  task automatic send_position(logic [31:0] lon, logic [31:0] lat, logic [27:0] h);
    in_tdata  = {4'b0, h, lat, lon};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  // Lowers valid, waits for every due result and lets the pipeline settle.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.coords_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [g2e_pkg::IDX_W-1:0] idx, logic [g2e_pkg::CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Mostly latitudes within the poles and heights in the usual range, with
  // some full-width patterns so that every bit of every field toggles.
  task automatic send_random(int count);
    logic [31:0] lat;
    logic [27:0] h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        lat = $urandom();
      end else begin
        lat = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      end
      if ($urandom_range(0, 4) == 0) begin
        h = 28'($urandom());
      end else begin
        h = 28'($urandom_range(0, 101000000) - 1000000);
      end
      send_position($urandom(), lat, h);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed positions on the reset ellipsoid: the angle extremes, the
    // poles, latitudes beyond a pole, the quarter-turn boundary of the
    // longitude fold and the height extremes.
    send_position(32'h0000_0000, 32'h0000_0000, 28'd0);
    send_position(32'h7FFF_FFFF, 32'h4000_0000, 28'h7FF_FFFF);
    send_position(32'h8000_0000, 32'hC000_0000, 28'h800_0000);
    send_position(32'h4000_0000, 32'h7FFF_FFFF, 28'd100000000);
    send_position(32'hC000_0000, 32'h8000_0000, -28'sd1000000);
    send_position(32'h4000_0001, 32'h4000_0001, 28'hFFF_FFFF);
    send_position(32'hBFFF_FFFF, 32'hBFFF_FFFF, 28'd1);
    send_position(32'h3FFF_FFFF, 32'h2000_0000, 28'd123456);
    send_position(32'hFFFF_FFFF, 32'hE000_0000, 28'd8848000);
    send_position(32'h0000_0001, 32'h0000_0001, 28'h555_5555);
    send_position(32'h5555_5555, 32'h2AAA_AAAA, 28'hAAA_AAAA);
    send_position(32'hAAAA_AAAA, 32'hD555_5555, 28'd0);
    send_random(140);

    // The sender holds off here until every result has come back.
    in_tvalid = 1'b0;
    while (sb.coords_due.size() != 0) @(negedge clk);
    send_random(20);

    // Largest radius with a sphere so that the outputs saturate, then a zero radius
    // with the eccentricity at its top so that N collapses to zero.
    drain();
    write_reg(g2e_pkg::REG_RADIUS, 33'h1_FFFF_FFFF);
    write_reg(g2e_pkg::REG_ECC, 33'd0);
    send_position(32'h0000_0000, 32'h0000_0000, 28'h7FF_FFFF);
    send_position(32'h8000_0000, 32'h4000_0000, 28'h800_0000);
    send_random(150);

    drain();
    write_reg(g2e_pkg::REG_RADIUS, 33'd0);
    write_reg(g2e_pkg::REG_ECC, 33'hFFFF_FFFF);
    send_position(32'h2000_0000, 32'h4000_0000, 28'd100000000);
    send_random(100);

    drain();
    write_reg(g2e_pkg::REG_RADIUS, 33'd1);
    send_random(60);

    drain();
    write_reg(g2e_pkg::REG_RADIUS, 33'd6378137000);
    write_reg(g2e_pkg::REG_ECC, 33'hFFFF_FFFF);
    send_position(32'h0000_0000, 32'h4000_0000, 28'd0);
    send_random(100);

    // A random ellipsoid, then WGS84 once more.
    drain();
    write_reg(g2e_pkg::REG_RADIUS, {1'($urandom_range(0, 1)), 32'($urandom())});
    write_reg(g2e_pkg::REG_ECC, 33'($urandom()));
    send_random(100);

    drain();
    write_reg(g2e_pkg::REG_RADIUS, 33'd6378137000);
    write_reg(g2e_pkg::REG_ECC, 33'd28752143);
    send_random(100);

    drain();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
